FILE: hw/rtl/cleb_pkg.sv
// ----------------------------------------------------------------------------
// cleb_pkg
// Shared constants, action codes and result type for the line edit buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cleb_pkg;

    // Line capacity in characters (1..63)
    localparam int CAPACITY = 63;
    // Width of length / cursor / position counters (holds 0..CAPACITY)
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Width of a text memory address
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    // Stored characters are 7-bit printable codes
    localparam int CHAR_W   = 7;

    // Printable key range
    localparam logic [7:0] KEY_LOW  = 8'd32;
    localparam logic [7:0] KEY_HIGH = 8'd126;

    // Action codes
    localparam logic [2:0] ACT_TYPE  = 3'd0;
    localparam logic [2:0] ACT_ERASE = 3'd1;
    localparam logic [2:0] ACT_LEFT  = 3'd2;
    localparam logic [2:0] ACT_RIGHT = 3'd3;
    localparam logic [2:0] ACT_HOME  = 3'd4;
    localparam logic [2:0] ACT_END   = 3'd5;
    localparam logic [2:0] ACT_PRINT = 3'd6;

    // One result beat
    typedef struct packed {
        logic       accepted;
        logic [7:0] char_out;
        logic       is_last;
    } t_result;

endpackage

FILE: hw/rtl/cleb_if.sv
// ----------------------------------------------------------------------------
// cleb_in_if / cleb_out_if
// Valid/ready channels for edit actions and for result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cleb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] key_code;
    logic [7:0] separator;

    modport source (output valid, output action, output key_code, output separator,
                    input ready);
    modport sink   (input valid, input action, input key_code, input separator,
                    output ready);
endinterface

interface cleb_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [7:0] char_out;
    logic       is_last;

    modport source (output valid, output accepted, output char_out, output is_last,
                    input ready);
    modport sink   (input valid, input accepted, input char_out, input is_last,
                    output ready);
endinterface

FILE: hw/rtl/cleb_out_fifo.sv
// ----------------------------------------------------------------------------
// cleb_out_fifo
// Two-entry result queue; decouples the editor from output backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cleb_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cleb_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    output cleb_pkg::t_result o_data,
    input  logic             i_pop
);

    cleb_pkg::t_result r_data [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;
    logic              pop_fire;
    logic              push_fire;

    assign o_space   = (r_count != 2'd2);
    assign o_valid   = (r_count != 2'd0);
    assign o_data    = r_data[r_rptr];
    assign pop_fire  = i_pop && o_valid;
    assign push_fire = i_push && o_space;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_data[r_wptr] <= i_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push_fire) r_wptr <= ~r_wptr;
            if (pop_fire)  r_rptr <= ~r_rptr;
            unique case ({push_fire, pop_fire})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("result queue pointers disagree with count");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_space) |-> (r_count == 2'd2))
        else $error("push refused while queue has space");

endmodule

FILE: hw/rtl/cursor_line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_top
// One-line text buffer with a cursor. Text lives in a synchronous RAM; inserts and
// erases shift entries in it; print streams it one beat a cycle while the queue has space.
//
// Moves, home, end, rejects and edits at line end queue their beat at the
//   accepting edge. Mid-line type shifts entries through S_INS, writes the key in
//   S_KEY, then queues its beat from S_RESP; mid-line erase shifts through S_ERA,
//   then S_RESP, one RAM shift per cycle on the single write port. Print sends
//   length + 1 beats; the next item waits for an idle sequencer and queue space.
// Reset: clears length, cursor, sequencer and result queue; text RAM is kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_line_edit_buffer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cleb_in_if.sink    i_item,
    cleb_out_if.source o_res
);

    localparam int CW = cleb_pkg::CNT_W;
    localparam int AW = cleb_pkg::ADDR_W;
    localparam int DW = cleb_pkg::CHAR_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_KEY   = 3'd2;
    localparam logic [2:0] S_ERA   = 3'd3;
    localparam logic [2:0] S_PRINT = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    localparam logic [CW-1:0] CAP = CW'(cleb_pkg::CAPACITY);

    // Text RAM
    logic [DW-1:0] r_text [cleb_pkg::CAPACITY];
    logic [DW-1:0] r_rdata;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_len,   n_len;
    logic [CW-1:0] r_cur,   n_cur;
    logic [DW-1:0] r_key,   n_key;
    logic [7:0]    r_sep,   n_sep;
    logic          r_acc,   n_acc;
    logic [CW-1:0] r_widx,  n_widx;
    logic [CW-1:0] r_ridx,  n_ridx;
    logic [CW-1:0] r_k,     n_k;
    logic          r_have,  n_have;

    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [CW-1:0] mem_raddr;

    logic              in_fire;
    logic              key_ok;
    logic              fifo_space;
    logic              push;
    cleb_pkg::t_result push_data;
    logic              fifo_valid;
    cleb_pkg::t_result fifo_data;

    logic at_sep;
    logic consume;
    logic issue;
    logic pr_fire;
    logic pr_last;

    assign i_item.ready = (r_state == S_IDLE) && fifo_space;
    assign in_fire      = i_item.valid && i_item.ready;
    assign key_ok       = (i_item.key_code >= cleb_pkg::KEY_LOW) &&
                          (i_item.key_code <= cleb_pkg::KEY_HIGH);

    // Print streaming controls
    assign at_sep  = (r_k == r_cur);
    assign pr_last = (r_k == r_len);
    assign pr_fire = (r_state == S_PRINT) && fifo_space && (at_sep || r_have);
    assign consume = pr_fire && !at_sep;
    assign issue   = (r_state == S_PRINT) && (r_ridx < r_len) && (!r_have || consume);

    // Next-state and RAM port control
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cur     = r_cur;
        n_key     = r_key;
        n_sep     = r_sep;
        n_acc     = r_acc;
        n_widx    = r_widx;
        n_ridx    = r_ridx;
        n_k       = r_k;
        n_have    = r_have;
        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = r_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_ridx;
        push      = 1'b0;
        push_data = '{accepted: 1'b1, char_out: 8'd0, is_last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_item.action)
                        cleb_pkg::ACT_TYPE: begin
                            if (!key_ok || r_len == CAP) begin
                                push               = 1'b1;
                                push_data.accepted = 1'b0;
                            end else if (r_cur == r_len) begin
                                // append: no shift needed
                                mem_we    = 1'b1;
                                mem_waddr = r_cur;
                                mem_wdata = i_item.key_code[DW-1:0];
                                n_len     = r_len + 1'b1;
                                n_cur     = r_cur + 1'b1;
                                push      = 1'b1;
                            end else begin
                                n_key     = i_item.key_code[DW-1:0];
                                mem_re    = 1'b1;
                                mem_raddr = r_len - 1'b1;
                                n_widx    = r_len;
                                n_state   = S_INS;
                            end
                        end
                        cleb_pkg::ACT_ERASE: begin
                            if (r_cur == '0) begin
                                push               = 1'b1;
                                push_data.accepted = 1'b0;
                            end else if (r_cur == r_len) begin
                                n_len = r_len - 1'b1;
                                n_cur = r_cur - 1'b1;
                                push  = 1'b1;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_cur;
                                n_widx    = r_cur - 1'b1;
                                n_state   = S_ERA;
                            end
                        end
                        cleb_pkg::ACT_LEFT: begin
                            if (r_cur != '0) n_cur = r_cur - 1'b1;
                            push = 1'b1;
                        end
                        cleb_pkg::ACT_RIGHT: begin
                            if (r_cur < r_len) n_cur = r_cur + 1'b1;
                            push = 1'b1;
                        end
                        cleb_pkg::ACT_HOME: begin
                            n_cur = '0;
                            push  = 1'b1;
                        end
                        cleb_pkg::ACT_END: begin
                            n_cur = r_len;
                            push  = 1'b1;
                        end
                        cleb_pkg::ACT_PRINT: begin
                            n_sep   = i_item.separator;
                            n_k     = '0;
                            n_ridx  = '0;
                            n_have  = 1'b0;
                            n_state = S_PRINT;
                        end
                        default: begin
                            push               = 1'b1;
                            push_data.accepted = 1'b0;
                        end
                    endcase
                end
            end

            // Shift right: write entry widx from entry widx-1, moving down
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_widx;
                mem_wdata = r_rdata;
                if ({1'b0, r_widx} > ({1'b0, r_cur} + 1'b1)) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_widx - CW'(2);
                    n_widx    = r_widx - 1'b1;
                end else begin
                    n_state = S_KEY;
                end
            end

            // Drop the new key into the gap at the cursor
            S_KEY: begin
                mem_we    = 1'b1;
                mem_waddr = r_cur;
                mem_wdata = r_key;
                n_len     = r_len + 1'b1;
                n_cur     = r_cur + 1'b1;
                n_acc     = 1'b1;
                n_state   = S_RESP;
            end

            // Shift left: write entry widx from entry widx+1, moving up
            S_ERA: begin
                mem_we    = 1'b1;
                mem_waddr = r_widx;
                mem_wdata = r_rdata;
                if (({1'b0, r_widx} + 2'd2) < {1'b0, r_len}) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_widx + CW'(2);
                    n_widx    = r_widx + 1'b1;
                end else begin
                    n_len   = r_len - 1'b1;
                    n_cur   = r_cur - 1'b1;
                    n_acc   = 1'b1;
                    n_state = S_RESP;
                end
            end

            // Stream characters with the separator at the cursor
            S_PRINT: begin
                mem_re    = issue;
                mem_raddr = r_ridx;
                if (issue) n_ridx = r_ridx + 1'b1;
                n_have = issue || (r_have && !consume);
                if (pr_fire) begin
                    push               = 1'b1;
                    push_data.char_out = at_sep ? r_sep : 8'(r_rdata);
                    push_data.is_last  = pr_last;
                    n_k                = r_k + 1'b1;
                    if (pr_last) n_state = S_IDLE;
                end
            end

            S_RESP: begin
                if (fifo_space) begin
                    push               = 1'b1;
                    push_data.accepted = r_acc;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Text RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_text[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_text[mem_raddr[AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_cur   <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_cur   <= n_cur;
            r_have  <= n_have;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_sep  <= n_sep;
        r_acc  <= n_acc;
        r_widx <= n_widx;
        r_ridx <= n_ridx;
        r_k    <= n_k;
    end

    // Result queue
    cleb_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_space (fifo_space),
        .o_valid (fifo_valid),
        .o_data  (fifo_data),
        .i_pop   (o_res.ready)
    );

    assign o_res.valid    = fifo_valid;
    assign o_res.accepted = fifo_data.accepted;
    assign o_res.char_out = fifo_data.char_out;
    assign o_res.is_last  = fifo_data.is_last;

    a_cur_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor past end of line");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CAP)
        else $error("line length exceeds capacity");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> fifo_space)
        else $error("result beat pushed into full queue");

    a_print_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pr_fire && pr_last) |=> (r_state == S_IDLE))
        else $error("print did not return to idle after last beat");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRINT && r_have) |-> (r_ridx != '0))
        else $error("print holds data without a read issued");

endmodule

FILE: sim/tb_cursor_line_edit_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_cursor_line_edit_buffer_top
// Self-checking bench for the line edit buffer. It starts with a short table
// of directed edits and prints, then runs random bursts of keystrokes that
// grow, shrink and walk the line. A line model in the bench predicts the result
// beats, apart from typed table rows. The receiver stalls in changing patterns,
// and once it holds off long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cursor_line_edit_buffer_top;

    localparam int         CLK_HALF_NS    = 4;
    localparam int         RESET_CYCLES   = 9;
    localparam int         RANDOM_ITEMS   = 470;
    localparam int         GROW_ITEMS     = 150;
    localparam int         PHASE_ITEMS    = 40;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 100;
    localparam int         TIMEOUT_CYCLES = 600000;
    // action 7 has no name in the package
    localparam logic [2:0] ACT_UNDEF      = 3'd7;

    // fill modes for the random part
    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    // one row of the directed table
    typedef struct {
        logic [2:0]        action;
        logic [7:0]        key_code;
        logic [7:0]        separator;
        bit                typed;
        cleb_pkg::t_result beat;
    } t_edit_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cleb_in_if  item_ch ();
    cleb_out_if res_ch ();

    cursor_line_edit_buffer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch)
    );

    // bench copy of the line
    logic [cleb_pkg::CHAR_W-1:0] line_text [cleb_pkg::CAPACITY];
    int                          line_len;
    int                          cursor;

    cleb_pkg::t_result expected_beats [$];
    t_edit_row         edit_rows [$];
    int                error_cnt  = 0;
    int                cycle_cnt  = 0;
    logic              hold_req   = 1'b0;
    logic              hold_done  = 1'b0;
    int                hold_left  = 0;
    int                rx_mode    = 0;
    int                rx_phase   = 0;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= TIMEOUT_CYCLES) begin
            $display("%0t timeout, %0d beats still expected", $realtime,
                     expected_beats.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: stall pattern re-picked at each phase wrap, one long hold-off
    always @(posedge i_clk) begin
        rx_phase <= (rx_phase == 49) ? 0 : rx_phase + 1;
        if (rx_phase == 49) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            res_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            case (rx_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                2:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                default: res_ch.ready <= (rx_phase[1:0] != 2'd3);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        cleb_pkg::t_result got;
        cleb_pkg::t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.accepted = res_ch.accepted;
            got.char_out = res_ch.char_out;
            got.is_last  = res_ch.is_last;
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: got acc=%0d ch=%02h last=%0d",
                         $realtime, got.accepted, got.char_out, got.is_last);
                error_cnt <= error_cnt + 1;
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: exp acc=%0d ch=%02h last=%0d got %0d %02h %0d",
                             $realtime, want.accepted, want.char_out, want.is_last,
                             got.accepted, got.char_out, got.is_last);
                    error_cnt <= error_cnt + 1;
                end
            end
        end
    end

    // Apply one action to the bench line; queue its beats when asked.
    task automatic apply_edit(input logic [2:0] act, input logic [7:0] key,
                              input logic [7:0] sep, input bit queue_beats);
        cleb_pkg::t_result beats [$];
        cleb_pkg::t_result b;
        logic              acc;
        acc = 1'b1;
        case (act)
            cleb_pkg::ACT_TYPE: begin
                if (key < cleb_pkg::KEY_LOW || key > cleb_pkg::KEY_HIGH ||
                    line_len >= cleb_pkg::CAPACITY) begin
                    acc = 1'b0;
                end else begin
                    for (int i = line_len; i > cursor; i--) begin
                        line_text[i] = line_text[i-1];
                    end
                    line_text[cursor] = key[cleb_pkg::CHAR_W-1:0];
                    line_len++;
                    cursor++;
                end
            end
            cleb_pkg::ACT_ERASE: begin
                if (cursor == 0) begin
                    acc = 1'b0;
                end else begin
                    for (int i = cursor; i < line_len; i++) begin
                        line_text[i-1] = line_text[i];
                    end
                    line_len--;
                    cursor--;
                end
            end
            cleb_pkg::ACT_LEFT:  if (cursor > 0) cursor--;
            cleb_pkg::ACT_RIGHT: if (cursor < line_len) cursor++;
            cleb_pkg::ACT_HOME:  cursor = 0;
            cleb_pkg::ACT_END:   cursor = line_len;
            cleb_pkg::ACT_PRINT: ;
            default:             acc = 1'b0;
        endcase
        if (act == cleb_pkg::ACT_PRINT) begin
            // text before the cursor, separator, text after it
            for (int i = 0; i < line_len; i++) begin
                if (i == cursor) begin
                    b = '{accepted: 1'b1, char_out: sep, is_last: 1'b0};
                    beats.push_back(b);
                end
                b = '{accepted: 1'b1, char_out: {1'b0, line_text[i]}, is_last: 1'b0};
                beats.push_back(b);
            end
            if (cursor == line_len) begin
                b = '{accepted: 1'b1, char_out: sep, is_last: 1'b0};
                beats.push_back(b);
            end
            beats[beats.size()-1].is_last = 1'b1;
        end else begin
            b = '{accepted: acc, char_out: 8'd0, is_last: 1'b1};
            beats.push_back(b);
        end
        if (queue_beats) begin
            foreach (beats[i]) expected_beats.push_back(beats[i]);
        end
    endtask

    // Offer one action and return at the edge where it is taken.
    task automatic offer_edit(input logic [2:0] act, input logic [7:0] key,
                              input logic [7:0] sep);
        item_ch.valid     <= 1'b1;
        item_ch.action    <= act;
        item_ch.key_code  <= key;
        item_ch.separator <= sep;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [2:0] act, input logic [7:0] key,
                           input logic [7:0] sep, input bit typed,
                           input logic acc, input logic [7:0] ch);
        t_edit_row r;
        r.action    = act;
        r.key_code  = key;
        r.separator = sep;
        r.typed     = typed;
        r.beat      = '{accepted: acc, char_out: ch, is_last: 1'b1};
        edit_rows.push_back(r);
    endtask

    // Weighted action pick for the random part.
    function automatic logic [2:0] pick_action(input int mode);
        int type_w;
        int erase_w;
        int r;
        type_w  = (mode == MODE_GROW) ? 65 : (mode == MODE_SHRINK) ? 15 : 35;
        erase_w = (mode == MODE_GROW) ? 5  : (mode == MODE_SHRINK) ? 35 : 20;
        r = $urandom_range(0, type_w + erase_w + 37);
        if (r < type_w)                 return cleb_pkg::ACT_TYPE;
        r -= type_w;
        if (r < erase_w)                return cleb_pkg::ACT_ERASE;
        r -= erase_w;
        if (r < 8)                      return cleb_pkg::ACT_LEFT;
        if (r < 16)                     return cleb_pkg::ACT_RIGHT;
        if (r < 20)                     return cleb_pkg::ACT_HOME;
        if (r < 24)                     return cleb_pkg::ACT_END;
        if (r < 36)                     return cleb_pkg::ACT_PRINT;
        return ACT_UNDEF;
    endfunction

    // stimulus
    initial begin
        int         burst_left;
        int         gap;
        int         mode;
        logic [2:0] act;
        logic [7:0] key;
        logic [7:0] sep;

        item_ch.valid     = 1'b0;
        item_ch.action    = cleb_pkg::ACT_HOME;
        item_ch.key_code  = 8'd0;
        item_ch.separator = 8'd0;
        res_ch.ready      = 1'b0;
        line_len          = 0;
        cursor            = 0;

        // directed table: typed expectations where obvious, model elsewhere
        add_row(cleb_pkg::ACT_PRINT, 8'h00, 8'h00, 1, 1'b1, 8'h00);  // empty line print
        add_row(cleb_pkg::ACT_ERASE, 8'h00, 8'h00, 1, 1'b0, 8'h00);  // erase at start
        add_row(cleb_pkg::ACT_LEFT,  8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_RIGHT, 8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'd31, 8'h00, 1, 1'b0, 8'h00);  // just below printable
        add_row(cleb_pkg::ACT_TYPE,  8'd127, 8'h00, 1, 1'b0, 8'h00); // just above printable
        add_row(cleb_pkg::ACT_TYPE,  8'h00, 8'h00, 1, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'hFF, 8'hFF, 1, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'd32, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'd126, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'h41, 8'h00, 1, 1'b1, 8'h00);
        add_row(ACT_UNDEF,           8'hFF, 8'hFF, 1, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_HOME,  8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_TYPE,  8'h7A, 8'h00, 1, 1'b1, 8'h00);  // insert at front
        add_row(cleb_pkg::ACT_PRINT, 8'h00, 8'hFF, 0, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_RIGHT, 8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_ERASE, 8'h00, 8'h00, 1, 1'b1, 8'h00);  // erase mid-line
        add_row(cleb_pkg::ACT_END,   8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_RIGHT, 8'h00, 8'h00, 1, 1'b1, 8'h00);  // right at line end
        add_row(cleb_pkg::ACT_PRINT, 8'h00, 8'h7C, 0, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_LEFT,  8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_PRINT, 8'h00, 8'h80, 0, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_HOME,  8'h00, 8'h00, 1, 1'b1, 8'h00);
        add_row(cleb_pkg::ACT_ERASE, 8'h00, 8'h00, 1, 1'b0, 8'h00);
        add_row(cleb_pkg::ACT_PRINT, 8'h00, 8'h2E, 0, 1'b0, 8'h00);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (edit_rows[i]) begin
            offer_edit(edit_rows[i].action, edit_rows[i].key_code,
                       edit_rows[i].separator);
            apply_edit(edit_rows[i].action, edit_rows[i].key_code,
                       edit_rows[i].separator, !edit_rows[i].typed);
            if (edit_rows[i].typed) begin
                expected_beats.push_back(edit_rows[i].beat);
            end
        end

        // random part: grow the line first, then wander
        hold_req   <= 1'b1;
        burst_left = $urandom_range(1, 40);
        mode       = MODE_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= GROW_ITEMS && (n % PHASE_ITEMS) == 0) begin
                mode = $urandom_range(MODE_GROW, MODE_MIXED);
            end
            if (burst_left == 0) begin
                item_ch.valid <= 1'b0;
                gap = $urandom_range(1, 12);
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            act = pick_action(mode);
            key = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(32, 126));
            sep = 8'($urandom_range(0, 255));
            offer_edit(act, key, sep);
            apply_edit(act, key, sep, 1'b1);
        end
        item_ch.valid <= 1'b0;

        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0 && expected_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
